/* hdl/ppm_pulse_train_decoder_macros.svh */
// Assertion macros shared by the PPM pulse train decoder.
`ifndef PPM_PULSE_TRAIN_DECODER_MACROS_SVH
`define PPM_PULSE_TRAIN_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define PPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppd assertion failed");
// Next-cycle implication, checked while out of reset.
`define PPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppd assertion failed");
`else
`define PPD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/ppd_pkg.sv */
// Package of constants and types for the PPM pulse train decoder.
`default_nettype none
package ppd_pkg;

  // Frame and timer geometry.
  localparam int NUM_CHANNELS = 6;
  localparam int TIMER_BITS   = 16;
  localparam int CHAN_W       = 7;
  localparam int CHIDX_W      = 3;
  localparam int WRAP_W       = 17;
  localparam int MS_W         = 32;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_WRAP  = 3'd0,
    REG_SYNC_MIN    = 3'd1,
    REG_PULSE_OFS   = 3'd2,
    REG_FULL_SCALE  = 3'd3,
    REG_TIMEOUT_MS  = 3'd4
  } cfg_reg_t;

  // Event codes carried by in_cmd.
  localparam logic CMD_CAPTURE  = 1'b0;
  localparam logic CMD_OVERFLOW = 1'b1;

  // Register values after reset.
  localparam logic [WRAP_W-1:0]     RST_TIMER_WRAP = 17'd65536;
  localparam logic [TIMER_BITS-1:0] RST_SYNC_MIN   = 16'd500;
  localparam logic [TIMER_BITS-1:0] RST_PULSE_OFS  = 16'd100;
  localparam logic [CHAN_W-1:0]     RST_FULL_SCALE = 7'd100;
  localparam logic [15:0]           RST_TIMEOUT_MS = 16'd30;

  // Decoded channel value.
  typedef logic [CHAN_W-1:0] chan_val_t;

endpackage
`default_nettype wire

/* hdl/ppm_pulse_train_decoder.sv */
// Top level of the PPM pulse train decoder: capture/overflow events in, sync and channels out.
`default_nettype none
`include "ppm_pulse_train_decoder_macros.svh"
// Decodes a six-channel radio-control PPM train from timer capture events. Each accepted
// item (a capture or a timer overflow) yields exactly one result item, the sync flag and
// all six channel values after that event. The decoder state is updated at the accepting
// edge and that state, held until the result item is taken, is the result register, so
// a new item is accepted in every cycle in which the previous result is taken or none is
// pending. Capture difference, wrap correction, sync test, clamp and silence test form the
// combinational paths from the inputs to the state. The user must write the configuration
// registers via cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module ppm_pulse_train_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [ppd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ppd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Event input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_cmd,
  input  wire logic [15:0]                     in_capture_value,
  input  wire logic [ppd_pkg::MS_W-1:0]        in_now_ms,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_in_sync,
  output ppd_pkg::chan_val_t                   out_chan_one,
  output ppd_pkg::chan_val_t                   out_chan_two,
  output ppd_pkg::chan_val_t                   out_chan_three,
  output ppd_pkg::chan_val_t                   out_chan_four,
  output ppd_pkg::chan_val_t                   out_chan_five,
  output ppd_pkg::chan_val_t                   out_chan_six
);
  import ppd_pkg::*;

  // Configuration registers.
  logic [WRAP_W-1:0]     timer_wrap_r;
  logic [TIMER_BITS-1:0] sync_min_r;
  logic [TIMER_BITS-1:0] pulse_ofs_r;
  logic [CHAN_W-1:0]     full_scale_r;
  logic [15:0]           timeout_r;

  // Decoder state; it doubles as the result register.
  logic [CHIDX_W-1:0]    next_chan_r, next_chan_nxt;
  logic [TIMER_BITS-1:0] prev_cap_r, prev_cap_nxt;
  logic [MS_W-1:0]       prev_ms_r, prev_ms_nxt;
  logic                  sync_r, sync_nxt;
  chan_val_t             chan_r [NUM_CHANNELS];
  chan_val_t             chan_nxt [NUM_CHANNELS];
  logic                  out_valid_r, out_valid_nxt;

  logic                  accept;
  logic [TIMER_BITS-1:0] cap;
  logic signed [17:0]    diff_raw;
  logic signed [17:0]    diff;
  logic signed [18:0]    ofs_diff;
  logic                  is_sync;
  logic                  awaiting;
  chan_val_t             clamped;
  logic [MS_W-1:0]       elapsed;
  logic                  timed_out;
  logic [CHIDX_W-1:0]    wr_idx;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_wrap_r <= RST_TIMER_WRAP;
      sync_min_r   <= RST_SYNC_MIN;
      pulse_ofs_r  <= RST_PULSE_OFS;
      full_scale_r <= RST_FULL_SCALE;
      timeout_r    <= RST_TIMEOUT_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMER_WRAP: timer_wrap_r <= cfg_data[WRAP_W-1:0];
        REG_SYNC_MIN:   sync_min_r   <= cfg_data[TIMER_BITS-1:0];
        REG_PULSE_OFS:  pulse_ofs_r  <= cfg_data[TIMER_BITS-1:0];
        REG_FULL_SCALE: full_scale_r <= cfg_data[CHAN_W-1:0];
        REG_TIMEOUT_MS: timeout_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: an item is taken whenever the pending result leaves or none is pending.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Tick difference, corrected for timer wrap, and the derived channel value.
  assign cap      = in_capture_value;
  assign diff_raw = $signed({2'b00, cap}) - $signed({2'b00, prev_cap_r});
  assign diff     = diff_raw[17] ? (diff_raw + $signed({1'b0, timer_wrap_r})) : diff_raw;
  assign is_sync  = diff > $signed({2'b00, sync_min_r});
  assign ofs_diff = $signed({diff[17], diff}) - $signed({3'b000, pulse_ofs_r});

  always_comb begin
    if (ofs_diff[18]) begin
      clamped = '0;
    end else if (ofs_diff > $signed({12'd0, full_scale_r})) begin
      clamped = full_scale_r;
    end else begin
      clamped = ofs_diff[CHAN_W-1:0];
    end
  end

  // Silence test for overflow events, modulo 2^32.
  assign elapsed   = in_now_ms - prev_ms_r;
  assign timed_out = elapsed > {16'd0, timeout_r};

  assign awaiting = (next_chan_r == '0) || (next_chan_r > CHIDX_W'(NUM_CHANNELS));
  assign wr_idx   = next_chan_r - CHIDX_W'(1);

  // Next decoder state for an accepted item.
  always_comb begin
    next_chan_nxt = next_chan_r;
    prev_cap_nxt  = prev_cap_r;
    prev_ms_nxt   = prev_ms_r;
    sync_nxt      = sync_r;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      chan_nxt[i] = chan_r[i];
    end
    if (in_cmd == CMD_OVERFLOW) begin
      if (timed_out) begin
        next_chan_nxt = '0;
        sync_nxt      = 1'b0;
      end
    end else begin
      prev_ms_nxt  = in_now_ms;
      prev_cap_nxt = cap;
      if (is_sync) begin
        // Sync gap: a gap in mid-frame also drops sync.
        if (next_chan_r != '0) begin
          sync_nxt = 1'b0;
        end
        next_chan_nxt = CHIDX_W'(1);
      end else if (awaiting) begin
        // Channel pulse with no frame started.
        sync_nxt      = 1'b0;
        next_chan_nxt = '0;
      end else begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (wr_idx == CHIDX_W'(i)) begin
            chan_nxt[i] = clamped;
          end
        end
        if (next_chan_r >= CHIDX_W'(NUM_CHANNELS)) begin
          sync_nxt      = 1'b1;
          next_chan_nxt = '0;
        end else begin
          next_chan_nxt = next_chan_r + CHIDX_W'(1);
        end
      end
    end
  end

  // Result valid flag.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State registers, updated at each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_chan_r <= '0;
      prev_cap_r  <= '0;
      prev_ms_r   <= '0;
      sync_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        next_chan_r <= next_chan_nxt;
        prev_cap_r  <= prev_cap_nxt;
        prev_ms_r   <= prev_ms_nxt;
        sync_r      <= sync_nxt;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          chan_r[i] <= chan_nxt[i];
        end
      end
    end
  end

  // Result item ports.
  assign out_valid      = out_valid_r;
  assign out_in_sync    = sync_r;
  assign out_chan_one   = chan_r[0];
  assign out_chan_two   = chan_r[1];
  assign out_chan_three = chan_r[2];
  assign out_chan_four  = chan_r[3];
  assign out_chan_five  = chan_r[4];
  assign out_chan_six   = chan_r[5];

  // Checks on the decoder's own state.
  `PPD_ASSERT_NOW(a_chan_range, clk, rst_n, 1'b1, next_chan_r <= CHIDX_W'(NUM_CHANNELS))
  `PPD_ASSERT_NOW(a_sync_waits, clk, rst_n, $rose(sync_r), next_chan_r == '0)
  `PPD_ASSERT_NEXT(a_sync_cause, clk, rst_n, !(accept && (in_cmd == CMD_CAPTURE)), !$rose(sync_r))
  `PPD_ASSERT_NEXT(a_ovf_keeps, clk, rst_n, accept && (in_cmd == CMD_OVERFLOW),
                   $stable(prev_cap_r) && $stable(prev_ms_r))

endmodule
`default_nettype wire

/* tb/ppm_pulse_train_decoder_tb.sv */
// Self-checking testbench for the PPM pulse train decoder, with a frame-tracking scoreboard.
`timescale 1ns / 100ps

module ppm_pulse_train_decoder_tb;
  import ppd_pkg::*;

  // Register indexes past the last real register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE  = 3'd7;

  localparam int MAX_SHOWN      = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 113;
  localparam int SETTLE_CYCLES  = 4;

  // Sync flag and channel values as the block presents them after one event.
  typedef struct {
    logic      sync;
    chan_val_t chans[NUM_CHANNELS];
  } ppm_frame_t;

  // Tracks the decoder state alongside the block and checks every result item.
  class ppm_frame_checker;
    logic [WRAP_W-1:0]     cfg_wrap;
    logic [TIMER_BITS-1:0] cfg_sync_min;
    logic [TIMER_BITS-1:0] cfg_ofs;
    logic [CHAN_W-1:0]     cfg_fs;
    logic [15:0]           cfg_tmo;

    int                    next_ch;
    logic [TIMER_BITS-1:0] last_cap;
    logic [MS_W-1:0]       last_ms;
    logic                  sync;
    chan_val_t             chans[NUM_CHANNELS];

    ppm_frame_t frames_due[$];
    int failures;
    int checked;
    int sync_seen;

    function new();
      cfg_wrap     = RST_TIMER_WRAP;
      cfg_sync_min = RST_SYNC_MIN;
      cfg_ofs      = RST_PULSE_OFS;
      cfg_fs       = RST_FULL_SCALE;
      cfg_tmo      = RST_TIMEOUT_MS;
      next_ch      = 0;
      last_cap     = '0;
      last_ms      = '0;
      sync         = 1'b0;
      foreach (chans[i]) chans[i] = '0;
      failures     = 0;
      checked      = 0;
      sync_seen    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TIMER_WRAP: cfg_wrap     = data[WRAP_W-1:0];
        REG_SYNC_MIN:   cfg_sync_min = data[TIMER_BITS-1:0];
        REG_PULSE_OFS:  cfg_ofs      = data[TIMER_BITS-1:0];
        REG_FULL_SCALE: cfg_fs       = data[CHAN_W-1:0];
        REG_TIMEOUT_MS: cfg_tmo      = data[15:0];
        default: ;
      endcase
    endfunction

    // Applies one accepted event and queues the frame the block should report.
    function void decode_event(logic cmd, logic [TIMER_BITS-1:0] cap, logic [MS_W-1:0] now);
      longint          gap;
      longint          level;
      logic [MS_W-1:0] silence;
      ppm_frame_t      want;
      if (cmd == CMD_OVERFLOW) begin
        silence = now - last_ms;
        if (silence > {16'd0, cfg_tmo}) begin
          next_ch = 0;
          sync    = 1'b0;
        end
      end else begin
        last_ms = now;
        gap = longint'(cap) - longint'(last_cap);
        if (gap < 0) gap += longint'(cfg_wrap);
        last_cap = cap;
        if (gap > longint'(cfg_sync_min)) begin
          // A sync gap in the middle of a frame loses sync.
          if (next_ch != 0) sync = 1'b0;
          next_ch = 1;
        end else if (next_ch == 0) begin
          // A channel pulse with no sync gap before it.
          sync = 1'b0;
        end else begin
          level = gap - longint'(cfg_ofs);
          if (level < 0) level = 0;
          if (level > longint'(cfg_fs)) level = longint'(cfg_fs);
          chans[next_ch-1] = chan_val_t'(level);
          if (next_ch >= NUM_CHANNELS) begin
            sync    = 1'b1;
            next_ch = 0;
          end else begin
            next_ch++;
          end
        end
      end
      want.sync  = sync;
      want.chans = chans;
      frames_due.push_back(want);
    endfunction

    function void flag(string what, int want, int got);
      failures++;
      if (failures <= MAX_SHOWN)
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_frame(ppm_frame_t got);
      ppm_frame_t want;
      checked++;
      if (got.sync) sync_seen++;
      if (frames_due.size() == 0) begin
        failures++;
        if (failures <= MAX_SHOWN)
          $display("%0t: result item arrived with no event outstanding", $time);
        return;
      end
      want = frames_due.pop_front();
      if (got.sync !== want.sync) flag("in_sync", want.sync, got.sync);
      for (int i = 0; i < NUM_CHANNELS; i++)
        if (got.chans[i] !== want.chans[i])
          flag($sformatf("channel %0d", i + 1), want.chans[i], got.chans[i]);
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_cmd;
  logic [15:0]           in_capture_value;
  logic [MS_W-1:0]       in_now_ms;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_in_sync;
  chan_val_t             out_chan_one;
  chan_val_t             out_chan_two;
  chan_val_t             out_chan_three;
  chan_val_t             out_chan_four;
  chan_val_t             out_chan_five;
  chan_val_t             out_chan_six;

  ppm_frame_checker      sb;
  ppm_frame_t            seen_frame;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    quiet_cycles;
  int                    n_items;
  int                    n_captures;
  int                    n_overflows;
  int                    n_settings;
  logic [15:0]           cap_pos;
  logic [MS_W-1:0]       ms_clock;

  ppm_pulse_train_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_capture_value (in_capture_value),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_in_sync      (out_in_sync),
    .out_chan_one     (out_chan_one),
    .out_chan_two     (out_chan_two),
    .out_chan_three   (out_chan_three),
    .out_chan_four    (out_chan_four),
    .out_chan_five    (out_chan_five),
    .out_chan_six     (out_chan_six)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random according to the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Results are checked before the event of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_frame.sync     = out_in_sync;
        seen_frame.chans[0] = out_chan_one;
        seen_frame.chans[1] = out_chan_two;
        seen_frame.chans[2] = out_chan_three;
        seen_frame.chans[3] = out_chan_four;
        seen_frame.chans[4] = out_chan_five;
        seen_frame.chans[5] = out_chan_six;
        sb.check_frame(seen_frame);
      end
      if (in_valid && in_ready) sb.decode_event(in_cmd, in_capture_value, in_now_ms);
    end
  end

  // Ends the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("** ppm_pulse_train_decoder: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Range of capture differences that the timer can produce under the current wrap.
  function automatic int unsigned timer_modulus();
    if (sb.cfg_wrap == 0 || sb.cfg_wrap > 65536) return 65536;
    return sb.cfg_wrap;
  endfunction

  function automatic logic [15:0] cap_after(int unsigned gap);
    return 16'((longint'(cap_pos) + longint'(gap)) % longint'(timer_modulus()));
  endfunction

  // Presents one item, with random idle cycles first, and waits until it is taken.
  task automatic send_event(input logic cmd, input logic [15:0] cap, input logic [MS_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_capture_value <= cap;
    in_now_ms        <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    if (cmd == CMD_OVERFLOW) n_overflows++;
    else n_captures++;
  endtask

  task automatic send_capture(input int unsigned gap);
    logic [15:0] c;
    c = cap_after(gap);
    ms_clock = ms_clock + $urandom_range(3);
    send_event(CMD_CAPTURE, c, ms_clock);
    cap_pos = c;
  endtask

  task automatic send_overflow(input logic [MS_W-1:0] silence);
    send_event(CMD_OVERFLOW, 16'($urandom), ms_clock + silence);
  endtask

  // Holds the sender off until every outstanding result item has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Writes every register while the block is idle, after a write to a spare index.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] wrap, input logic [CFG_DATA_W-1:0] smin,
                               input logic [CFG_DATA_W-1:0] ofs, input logic [CFG_DATA_W-1:0] fs,
                               input logic [CFG_DATA_W-1:0] tmo);
    logic [CFG_IDX_W-1:0]  ids[6];
    logic [CFG_DATA_W-1:0] vals[6];
    ids[0]  = CFG_IDX_W'($urandom_range(REG_LAST_SPARE, REG_FIRST_SPARE));
    vals[0] = '1;
    ids[1]  = REG_TIMER_WRAP;
    vals[1] = wrap;
    ids[2]  = REG_SYNC_MIN;
    vals[2] = smin;
    ids[3]  = REG_PULSE_OFS;
    vals[3] = ofs;
    ids[4]  = REG_FULL_SCALE;
    vals[4] = fs;
    ids[5]  = REG_TIMEOUT_MS;
    vals[5] = tmo;
    drain();
    cfg_we <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= ids[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(ids[i], vals[i]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // A sync gap followed by channel pulses around the clamp limits; some frames
  // are cut short or run long.
  task automatic send_frame();
    int unsigned span;
    int unsigned sync_lo;
    int unsigned sync_hi;
    int unsigned lo;
    int unsigned hi;
    int unsigned n_pulses;
    span    = timer_modulus() - 1;
    sync_lo = sb.cfg_sync_min + 1;
    sync_hi = sb.cfg_sync_min + 3000;
    if (sync_hi > span) sync_hi = span;
    if (sync_lo > sync_hi) sync_lo = sync_hi;
    lo = (sb.cfg_ofs > 40) ? sb.cfg_ofs - 40 : 0;
    hi = sb.cfg_ofs + sb.cfg_fs + 40;
    if (hi > sb.cfg_sync_min) hi = sb.cfg_sync_min;
    if (hi > span) hi = span;
    if (lo > hi) lo = hi;
    n_pulses = ($urandom_range(99) < 80) ? NUM_CHANNELS : $urandom_range(NUM_CHANNELS + 2);
    send_capture($urandom_range(sync_hi, sync_lo));
    repeat (n_pulses) send_capture($urandom_range(hi, lo));
  endtask

  task automatic random_phase();
    int             phase_end;
    int unsigned    pick;
    logic [15:0]    c;
    logic [MS_W-1:0] now;
    phase_end = n_items + PHASE_ITEMS;
    while (n_items < phase_end) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame();
      end else if (pick < 85) begin
        // Silence at, just past, below or far beyond the timeout.
        case ($urandom_range(3))
          0: send_overflow({16'd0, sb.cfg_tmo});
          1: send_overflow({16'd0, sb.cfg_tmo} + 1);
          2: send_overflow($urandom_range(sb.cfg_tmo));
          default: send_overflow($urandom);
        endcase
      end else begin
        // Noise: arbitrary captures and overflows at arbitrary times.
        c   = 16'($urandom);
        now = $urandom;
        if ($urandom_range(1)) begin
          send_event(CMD_OVERFLOW, c, now);
        end else begin
          send_event(CMD_CAPTURE, c, now);
          cap_pos  = c;
          ms_clock = now;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_TIMER_WRAP;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_cmd           <= CMD_CAPTURE;
    in_capture_value <= '0;
    in_now_ms        <= '0;
    n_items          = 0;
    n_captures       = 0;
    n_overflows      = 0;
    n_settings       = 0;
    cap_pos          = '0;
    ms_clock         = '0;
    send_idle_pct    = 16;
    recv_idle_pct    = 79;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings.
    send_overflow('0);
    // A channel pulse straight after reset, with no sync seen yet.
    send_capture(0);
    send_capture(600);
    // Below the offset, at the offset, at the sync threshold, mid-scale, at and above full scale.
    send_capture(50);
    send_capture(100);
    send_capture(500);
    send_capture(150);
    send_capture(200);
    send_capture(201);
    // Sync gap landing near the top of the timer, then pulses that wrap past zero.
    send_capture(65400 - int'(cap_pos));
    send_capture(110);
    send_capture(120);
    send_capture(130);
    // The largest gap, arriving while a channel is expected.
    send_capture(65535);
    for (int i = 0; i < NUM_CHANNELS; i++) send_capture(160 + 10 * i);
    // A channel pulse once the frame is complete drops sync.
    send_capture(120);
    send_capture(int'(RST_SYNC_MIN) + 1);
    // Silence exactly at the timeout keeps the frame; one more millisecond drops it.
    send_overflow({16'd0, RST_TIMEOUT_MS});
    send_overflow({16'd0, RST_TIMEOUT_MS} + 1);
    drain();

    // Random part across several register settings and idle patterns.
    apply_setting(17'd65536, 17'd500, 17'd100, 17'd100, 17'd30);
    random_phase();
    apply_setting(17'd65536, 17'd3000, 17'd1000, 17'd127, 17'd65535);
    random_phase();
    send_idle_pct = 79;
    recv_idle_pct = 16;
    apply_setting(17'd40000, 17'd200, 17'd0, 17'd0, 17'd0);
    random_phase();
    apply_setting(17'd0, 17'd500, 17'd100, 17'd100, 17'd30);
    random_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Run the millisecond clock across its wrap.
    ms_clock = 32'hFFFF_FFC0;
    apply_setting(17'h1FFFF, 17'd65535, 17'd65535, 17'd127, 17'd1);
    random_phase();
    apply_setting(17'd1, 17'd0, 17'd50, 17'd64, 17'd100);
    random_phase();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.failures += sb.pending();
      $display("%0t: %0d result items never arrived", $time, sb.pending());
    end
    $display("Sent %0d events (%0d captures, %0d overflows) over %0d register settings.",
             n_items, n_captures, n_overflows, n_settings + 1);
    $display("Checked %0d result items, %0d of them in sync; %0d failures.",
             sb.checked, sb.sync_seen, sb.failures);
    if (sb.failures == 0) begin
      $display("** ppm_pulse_train_decoder: PASSED **");
    end else begin
      $display("** ppm_pulse_train_decoder: FAILED **");
    end
    $finish;
  end

endmodule
